// ===== rtl/max_heap_priority_queue_defines.svh =====
// assertion macros for the max-heap priority queue
// expects clk_i, and rst_ni for MHPQ_ASSERT, in the scope of each use
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// checked only outside reset
`define MHPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define MHPQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helper functions of the max-heap priority queue
// no dependencies
package mhpq_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IN_W       = 32;
  localparam int unsigned CAP_W      = 7;
  localparam int unsigned FILL_W     = 7;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned KID_W      = IDX_W + 2;
  localparam int unsigned CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [IN_W-1:0]       word_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_FETCH,
    S_DN_RD,
    S_DN_CMP,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic ins_start;
    logic rem_start;
    logic set_overflow;
    logic set_underflow;
    logic write_cur;
    logic up_move;
    logic dn_load;
    logic rd_par;
    logic rd_kids;
    logic dn_move;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic leaf;
    logic up_move;
    logic dn_stop;
    logic out_busy;
  } sts_t;

  // input word to store width: truncate or sign extend
  function automatic data_t to_store(word_t v);
    data_t d;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      d[i] = v[(i < IN_W) ? i : IN_W - 1];
    end
    return d;
  endfunction

  // store entry to result word: low bits, sign extended if narrower
  function automatic word_t to_word(data_t d);
    word_t w;
    for (int i = 0; i < IN_W; i++) begin
      w[i] = d[(i < DATA_WIDTH) ? i : DATA_WIDTH - 1];
    end
    return w;
  endfunction

endpackage

// ===== rtl/mhpq_in_if.sv =====
`timescale 1ns / 1ps
// request channel of the priority queue: opcode and value
// depends on mhpq_pkg
interface mhpq_in_if;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  mhpq_pkg::word_t      value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ===== rtl/mhpq_out_if.sv =====
`timescale 1ns / 1ps
// response channel of the priority queue: result, status and fill count
// depends on mhpq_pkg
interface mhpq_out_if;
  logic                          valid;
  logic                          ready;
  mhpq_pkg::word_t               result_value;
  logic [1:0]                    status;
  logic [mhpq_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, output result_value, output status, output fill_count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input fill_count,
                  output ready);
endinterface

// ===== rtl/max_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// top level of the binary max-heap priority queue
// depends on mhpq_pkg, mhpq_in_if, mhpq_out_if, mhpq_ctrl and mhpq_datapath
//
//  channel   dir  handshake        payload
//  in_i      in   valid / ready    opcode, value
//  out_o     out  valid / ready    result_value, status, fill_count
//  cfg       in   cfg_we_i         cfg_wdata_i (capacity)
//
//  insert climbs from the new slot, moving each smaller parent down a level; remove
//    loads the root as result and the last entry as the moving value, then sinks it,
//    moving the larger child up while that child is larger; each level is one read
//    of the store's registered port plus one compare and write
//  a refused insert or empty remove goes straight from idle to the response step
//  reset clears the count and restores capacity 64; the store needs no clearing
//  out_o holds its result while stalled; the next transaction is taken meanwhile
//    and waits in its response step only if the previous result is still pending
module max_heap_priority_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mhpq_pkg::CAP_W-1:0]  cfg_wdata_i,
  mhpq_in_if.sink                     in_i,
  mhpq_out_if.source                  out_o
);

  mhpq_pkg::cmd_t cmd;
  mhpq_pkg::sts_t sts;

  // sequencer: one transaction at a time
  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  // store, sift registers and response register
  mhpq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_value_i   (in_i.value),
    .out_ready_i  (out_o.ready),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_result_o (out_o.result_value),
    .out_status_o (out_o.status),
    .out_fill_o   (out_o.fill_count)
  );

endmodule

// ===== rtl/mhpq_datapath.sv =====
`timescale 1ns / 1ps
// heap store, count, sift registers and response register of the priority queue
// depends on mhpq_pkg and max_heap_priority_queue_defines.svh
`include "max_heap_priority_queue_defines.svh"

module mhpq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mhpq_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  mhpq_pkg::word_t               in_value_i,
  input  logic                          out_ready_i,
  input  mhpq_pkg::cmd_t                cmd_i,
  output mhpq_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  output mhpq_pkg::word_t               out_result_o,
  output logic [1:0]                    out_status_o,
  output logic [mhpq_pkg::FILL_W-1:0]   out_fill_o
);

  logic [mhpq_pkg::CAP_W-1:0]  cap_q;
  logic [mhpq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [mhpq_pkg::IDX_W-1:0]  idx_q, idx_d;
  mhpq_pkg::data_t             cur_q, cur_d;
  mhpq_pkg::word_t             res_q, res_d;
  mhpq_pkg::status_e           stat_q, stat_d;

  mhpq_pkg::data_t             mem [mhpq_pkg::DEPTH];
  mhpq_pkg::data_t             rd_a_q, rd_b_q;
  logic [mhpq_pkg::IDX_W-1:0]  raddr_a, raddr_b;

  logic                        ov_q;
  mhpq_pkg::word_t             ores_q;
  mhpq_pkg::status_e           ost_q;
  logic [mhpq_pkg::FILL_W-1:0] ofill_q;

  logic [mhpq_pkg::IDX_W-1:0]  par;
  logic [mhpq_pkg::KID_W-1:0]  kid_l, kid_r, kid_n, child;
  logic                        r_ok, take_l, take_r;
  mhpq_pkg::data_t             v1, big_val, wdata;
  logic                        we;
  logic                        op_start;

  // heap index arithmetic
  assign par   = (idx_q - mhpq_pkg::IDX_W'(1)) >> 1;
  assign kid_l = (mhpq_pkg::KID_W'(idx_q) << 1) + mhpq_pkg::KID_W'(1);
  assign kid_r = (mhpq_pkg::KID_W'(idx_q) << 1) + mhpq_pkg::KID_W'(2);
  assign kid_n = mhpq_pkg::KID_W'(count_q);
  assign r_ok  = kid_r < kid_n;

  // sift-down pick: larger child, left wins a tie, moves only if strictly larger
  assign take_l  = cur_q < rd_a_q;
  assign v1      = take_l ? rd_a_q : cur_q;
  assign take_r  = r_ok && (v1 < rd_b_q);
  assign child   = take_r ? kid_r : kid_l;
  assign big_val = take_r ? rd_b_q : rd_a_q;

  always_comb begin
    sts_o.full     = (mhpq_pkg::CMP_W'(count_q) >= mhpq_pkg::CMP_W'(cap_q)) ||
                     (count_q >= mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH));
    sts_o.empty    = count_q == '0;
    sts_o.at_root  = idx_q == '0;
    sts_o.leaf     = kid_l >= kid_n;
    sts_o.up_move  = rd_a_q < cur_q;
    sts_o.dn_stop  = !take_l && !take_r;
    sts_o.out_busy = ov_q && !out_ready_i;
  end

  // read addresses
  always_comb begin
    if (cmd_i.rd_par) begin
      raddr_a = par;
    end else if (cmd_i.rd_kids) begin
      raddr_a = kid_l[mhpq_pkg::IDX_W-1:0];
    end else begin
      raddr_a = '0;
    end
    if (cmd_i.rd_kids) begin
      raddr_b = kid_r[mhpq_pkg::IDX_W-1:0];
    end else begin
      raddr_b = mhpq_pkg::IDX_W'(count_q - mhpq_pkg::CNT_W'(1));
    end
  end

  // single write port, hole method: the moving value lands once at the end
  assign we = cmd_i.write_cur || cmd_i.up_move || cmd_i.dn_move;
  always_comb begin
    priority if (cmd_i.up_move) begin
      wdata = rd_a_q;
    end else if (cmd_i.dn_move) begin
      wdata = big_val;
    end else begin
      wdata = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= wdata;
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

  // sift and response payload
  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    cur_d   = cur_q;
    res_d   = res_q;
    stat_d  = stat_q;
    if (cmd_i.ins_start) begin
      count_d = count_q + mhpq_pkg::CNT_W'(1);
      idx_d   = count_q[mhpq_pkg::IDX_W-1:0];
      cur_d   = mhpq_pkg::to_store(in_value_i);
      res_d   = '0;
      stat_d  = mhpq_pkg::STATUS_OK;
    end
    if (cmd_i.rem_start) begin
      count_d = count_q - mhpq_pkg::CNT_W'(1);
    end
    if (cmd_i.set_overflow) begin
      res_d  = '0;
      stat_d = mhpq_pkg::STATUS_OVERFLOW;
    end
    if (cmd_i.set_underflow) begin
      res_d  = '1;
      stat_d = mhpq_pkg::STATUS_UNDERFLOW;
    end
    if (cmd_i.dn_load) begin
      idx_d  = '0;
      cur_d  = rd_b_q;
      res_d  = mhpq_pkg::to_word(rd_a_q);
      stat_d = mhpq_pkg::STATUS_OK;
    end
    if (cmd_i.up_move) begin
      idx_d = par;
    end
    if (cmd_i.dn_move) begin
      idx_d = child[mhpq_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= mhpq_pkg::CAP_RESET;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (cmd_i.load_out) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
    stat_q <= stat_d;
    if (cmd_i.load_out) begin
      ores_q  <= res_q;
      ost_q   <= stat_q;
      ofill_q <= mhpq_pkg::FILL_W'(count_q);
    end
  end

  assign out_valid_o  = ov_q;
  assign out_result_o = ores_q;
  assign out_status_o = ost_q;
  assign out_fill_o   = ofill_q;

  assign op_start = cmd_i.ins_start || cmd_i.rem_start;

  `MHPQ_ASSERT(a_count_bound, count_q <= mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH), "count above depth")
  `MHPQ_ASSERT(a_count_step, !$stable(count_q) |-> $past(op_start), "stray count change")
  `MHPQ_ASSERT(a_ins_room, cmd_i.ins_start |-> !sts_o.full, "insert started on a full heap")
  `MHPQ_ASSERT(a_rem_held, cmd_i.rem_start |-> !sts_o.empty, "remove started on an empty heap")

endmodule

// ===== rtl/mhpq_ctrl.sv =====
`timescale 1ns / 1ps
// sequencer of the priority queue: accepts a transaction, walks the sift, issues the response
// depends on mhpq_pkg
module mhpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  input  mhpq_pkg::sts_t    sts_i,
  output logic              in_ready_o,
  output mhpq_pkg::cmd_t    cmd_o
);

  mhpq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mhpq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == mhpq_pkg::OP_INSERT) begin
            if (sts_i.full) begin
              cmd_o.set_overflow = 1'b1;
              state_d            = mhpq_pkg::S_RESP;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d         = mhpq_pkg::S_UP_RD;
            end
          end else begin
            if (sts_i.empty) begin
              cmd_o.set_underflow = 1'b1;
              state_d             = mhpq_pkg::S_RESP;
            end else begin
              cmd_o.rem_start = 1'b1;
              state_d         = mhpq_pkg::S_DN_FETCH;
            end
          end
        end
      end
      mhpq_pkg::S_UP_RD: begin
        if (sts_i.at_root) begin
          cmd_o.write_cur = 1'b1;
          state_d         = mhpq_pkg::S_RESP;
        end else begin
          cmd_o.rd_par = 1'b1;
          state_d      = mhpq_pkg::S_UP_CMP;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        if (sts_i.up_move) begin
          cmd_o.up_move = 1'b1;
          state_d       = mhpq_pkg::S_UP_RD;
        end else begin
          cmd_o.write_cur = 1'b1;
          state_d         = mhpq_pkg::S_RESP;
        end
      end
      mhpq_pkg::S_DN_FETCH: begin
        cmd_o.dn_load = 1'b1;
        state_d       = mhpq_pkg::S_DN_RD;
      end
      mhpq_pkg::S_DN_RD: begin
        if (sts_i.leaf) begin
          cmd_o.write_cur = 1'b1;
          state_d         = mhpq_pkg::S_RESP;
        end else begin
          cmd_o.rd_kids = 1'b1;
          state_d       = mhpq_pkg::S_DN_CMP;
        end
      end
      mhpq_pkg::S_DN_CMP: begin
        if (sts_i.dn_stop) begin
          cmd_o.write_cur = 1'b1;
          state_d         = mhpq_pkg::S_RESP;
        end else begin
          cmd_o.dn_move = 1'b1;
          state_d       = mhpq_pkg::S_DN_RD;
        end
      end
      mhpq_pkg::S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = mhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mhpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule
